@@ rtl/ulfr_pkg.sv @@
// shared types and constants of the length-prefixed uart frame receiver
package ulfr_pkg;

  localparam int TIMER_BITS = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int CMP_W      = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
  localparam int COUNT_W    = 17;
  localparam int LEN_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [COUNT_W-1:0] HDR_PLUS_LEN = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] CNT_LEN_HI   = COUNT_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0]            HEADER_RESET  = 8'd170;
  localparam logic [LEN_W-1:0]      MAX_LEN_RESET = 16'd1024;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [7:0]           header_byte;
    logic [LEN_W-1:0]     max_length;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       first_flag;
    logic       last_flag;
    logic       abort_flag;
    logic       sum_ok;
  } res_t;

endpackage

@@ rtl/uart_length_frame_receiver_unit.sv @@
// top level of the length-prefixed uart frame receiver
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata rx_byte, tuser cmd
//   m_*      out  m_tvalid/m_tready  tdata frame_byte, tlast last_flag, tuser flags
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// one beat per cycle sustained while the output is not stalled; a beat is held in
// the input register and its result, if any, is registered into the output register
// as it advances; the frame state updates then, so back-to-back beats chain directly
// a stalled output holds the input register, which then drops s_tready
// rst clears the frame state and handshake registers and resets the configuration
module uart_length_frame_receiver_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // rx_byte
  input  logic                           s_tuser,   // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // frame_byte
  output logic                           m_tlast,
  output logic [2:0]                     m_tuser,   // first_flag, abort_flag, sum_ok
  input  logic                           cfg_we,
  input  logic [ulfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ulfr_pkg::CFG_W-1:0]     cfg_data
);

  ulfr_pkg::cfg_t cfg;
  ulfr_pkg::res_t res;
  logic           res_valid;
  logic           in_valid;
  logic           in_cmd;
  logic [7:0]     in_byte;
  logic           advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  ulfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ulfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (advance),
    .cmd       (in_cmd),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tdata <= res.frame_byte;
      m_tlast <= res.last_flag;
      m_tuser <= {res.sum_ok, res.abort_flag, res.first_flag};
    end
  end

`ifndef NO_ASSERTIONS
  a_last_not_abort: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tuser[1]))
    else $error("last and abort on one beat");

  a_sum_only_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("sum_ok outside a last beat");

  a_first_alone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (!m_tlast && !m_tuser[1]))
    else $error("first beat also marked last or abort");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte) && $stable(in_cmd)))
    else $error("input register lost a beat while stalled");
`endif

endmodule

@@ rtl/ulfr_cfg.sv @@
// configuration registers of the frame receiver
module ulfr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ulfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ulfr_pkg::CFG_W-1:0]     cfg_data,
  output ulfr_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte   <= ulfr_pkg::HEADER_RESET;
      cfg.max_length    <= ulfr_pkg::MAX_LEN_RESET;
      cfg.timeout_ticks <= ulfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ulfr_pkg::REG_HEADER_BYTE:   cfg.header_byte   <= cfg_data[7:0];
        ulfr_pkg::REG_MAX_LENGTH:    cfg.max_length    <= cfg_data[ulfr_pkg::LEN_W-1:0];
        ulfr_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[ulfr_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ulfr_core.sv @@
// frame state and per-beat step logic of the frame receiver
module ulfr_core (
  input  logic           clk,
  input  logic           rst,
  input  ulfr_pkg::cfg_t cfg,
  input  logic           step,
  input  logic           cmd,
  input  logic [7:0]     rx_byte,
  output logic           res_valid,
  output ulfr_pkg::res_t res
);

  logic                              in_frame, in_frame_next;
  logic [ulfr_pkg::COUNT_W-1:0]      received_count, received_count_next;
  logic [ulfr_pkg::LEN_W-1:0]        expected_length, expected_length_next;
  logic [7:0]                        running_sum, running_sum_next;
  logic [ulfr_pkg::TIMER_BITS-1:0]   idle_ticks, idle_ticks_next;

  logic [ulfr_pkg::COUNT_W-1:0]      cnt_inc;
  logic [ulfr_pkg::LEN_W-1:0]        len_cur;
  logic [ulfr_pkg::TIMER_BITS-1:0]   idle_inc;
  logic                              frame_end;

  always_comb begin
    cnt_inc  = received_count + ulfr_pkg::COUNT_W'(1);
    len_cur  = (cnt_inc == ulfr_pkg::HDR_PLUS_LEN) ? {expected_length[15:8], rx_byte}
                                                    : expected_length;
    idle_inc = (&idle_ticks) ? idle_ticks : idle_ticks + ulfr_pkg::TIMER_BITS'(1);
    frame_end = (cnt_inc >= ulfr_pkg::HDR_PLUS_LEN) &&
                ((cnt_inc - ulfr_pkg::HDR_PLUS_LEN) == ulfr_pkg::COUNT_W'(len_cur));

    in_frame_next        = in_frame;
    received_count_next  = received_count;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    idle_ticks_next      = idle_ticks;
    res_valid            = 1'b0;
    res                  = '0;

    if (cmd == ulfr_pkg::CMD_TICK) begin
      if (in_frame) begin
        idle_ticks_next = idle_inc;
        if (ulfr_pkg::CMP_W'(idle_inc) > ulfr_pkg::CMP_W'(cfg.timeout_ticks)) begin
          in_frame_next        = 1'b0;
          received_count_next  = '0;
          expected_length_next = '0;
          running_sum_next     = '0;
          idle_ticks_next      = '0;
          res_valid            = 1'b1;
          res.abort_flag       = 1'b1;
        end
      end
    end else if (!in_frame) begin
      if (rx_byte == cfg.header_byte) begin
        in_frame_next        = 1'b1;
        received_count_next  = ulfr_pkg::COUNT_W'(1);
        expected_length_next = '0;
        running_sum_next     = rx_byte;
        idle_ticks_next      = '0;
        res_valid            = 1'b1;
        res.frame_byte       = rx_byte;
        res.first_flag       = 1'b1;
      end
    end else begin
      res_valid           = 1'b1;
      res.frame_byte      = rx_byte;
      idle_ticks_next     = '0;
      received_count_next = cnt_inc;
      if (cnt_inc == ulfr_pkg::CNT_LEN_HI) begin
        expected_length_next = {rx_byte, 8'h00};
      end else if (cnt_inc == ulfr_pkg::HDR_PLUS_LEN) begin
        expected_length_next = len_cur;
      end
      priority if ((cnt_inc == ulfr_pkg::HDR_PLUS_LEN) && (len_cur > cfg.max_length)) begin
        in_frame_next        = 1'b0;
        received_count_next  = '0;
        expected_length_next = '0;
        running_sum_next     = '0;
        res.abort_flag       = 1'b1;
      end else if (frame_end) begin
        in_frame_next        = 1'b0;
        received_count_next  = '0;
        expected_length_next = '0;
        running_sum_next     = '0;
        res.last_flag        = 1'b1;
        res.sum_ok           = (rx_byte == running_sum);
      end else begin
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      received_count  <= '0;
      expected_length <= '0;
      running_sum     <= '0;
      idle_ticks      <= '0;
    end else if (step) begin
      in_frame        <= in_frame_next;
      received_count  <= received_count_next;
      expected_length <= expected_length_next;
      running_sum     <= running_sum_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

endmodule
